FILE: design/ubf_pkg.sv
// Shared types, depths and widths for the buffered UART byte FIFOs.
package ubf_pkg;

  localparam int RX_DEPTH = 64;
  localparam int TX_DEPTH = 64;
  localparam int LEVEL_W  = 7;

  localparam int RX_PTR_W = $clog2(RX_DEPTH);
  localparam int TX_PTR_W = $clog2(TX_DEPTH);
  localparam int RX_CNT_W = ($clog2(RX_DEPTH + 1) > LEVEL_W) ? $clog2(RX_DEPTH + 1) : LEVEL_W;
  localparam int TX_CNT_W = ($clog2(TX_DEPTH + 1) > LEVEL_W) ? $clog2(TX_DEPTH + 1) : LEVEL_W;

  typedef enum logic [1:0] {
    KIND_RX_BYTE = 2'd0,
    KIND_READ    = 2'd1,
    KIND_SEND    = 2'd2,
    KIND_TX_DONE = 2'd3
  } kind_e;

  typedef struct packed {
    logic load;
    logic rx_push;
    logic rx_pop;
    logic tx_push;
    logic tx_direct;
    logic tx_pop;
    logic send_rej;
  } ubf_cmd_t;

  typedef struct packed {
    logic rx_empty;
    logic rx_full;
    logic tx_empty;
    logic tx_full;
  } ubf_status_t;

endpackage

FILE: design/buffered_uart_byte_fifos.sv
// Top level of the buffered UART byte FIFOs: controller plus datapath.
//
//   channel | handshake               | payload
//   --------+-------------------------+-------------------------------------------
//   in      | in_valid_i / in_ready_o | kind_i data_i rx_error_i tx_idle_i
//   out     | out_valid_o/out_ready_i | read_valid_o read_data_o tx_strobe_o
//           |                         | tx_byte_o send_rejected_o rx_level_o tx_level_o
//
// One beat in gives one beat out; the result is valid the cycle after acceptance.
// Items are handled one at a time, with a single registered memory access per
// item; a new input beat is accepted only after the previous result is taken.
// in_ready_o is registered and rises in the cycle after reset release; no clearing pass is needed.
// A stalled result holds and blocks the next input beat.
module buffered_uart_byte_fifos
  import ubf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         kind_i,
  input  logic [7:0]         data_i,
  input  logic               rx_error_i,
  input  logic               tx_idle_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               read_valid_o,
  output logic [7:0]         read_data_o,
  output logic               tx_strobe_o,
  output logic [7:0]         tx_byte_o,
  output logic               send_rejected_o,
  output logic [LEVEL_W-1:0] rx_level_o,
  output logic [LEVEL_W-1:0] tx_level_o
);

  ubf_cmd_t    cmd;
  ubf_status_t status;

  ubf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_i      (kind_i),
    .rx_error_i  (rx_error_i),
    .tx_idle_i   (tx_idle_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ubf_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .data_i          (data_i),
    .status_o        (status),
    .read_valid_o    (read_valid_o),
    .read_data_o     (read_data_o),
    .tx_strobe_o     (tx_strobe_o),
    .tx_byte_o       (tx_byte_o),
    .send_rejected_o (send_rejected_o),
    .rx_level_o      (rx_level_o),
    .tx_level_o      (tx_level_o)
  );

endmodule

FILE: design/ubf_ctrl.sv
// Controller: handshake sequencing and item decode into datapath commands.
module ubf_ctrl
  import ubf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [1:0]  kind_i,
  input  logic        rx_error_i,
  input  logic        tx_idle_i,
  input  ubf_status_t status_i,
  output ubf_cmd_t    cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;
  logic   go;

  assign go          = in_valid_i & in_ready_q;
  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o      = '0;
    cmd_o.load = go;
    if (go) begin
      unique case (kind_e'(kind_i))
        KIND_RX_BYTE: cmd_o.rx_push = ~rx_error_i;
        KIND_READ:    cmd_o.rx_pop  = ~status_i.rx_empty;
        KIND_SEND: begin
          if (tx_idle_i && status_i.tx_empty) begin
            cmd_o.tx_direct = 1'b1;
          end else if (status_i.tx_full) begin
            cmd_o.send_rej = 1'b1;
          end else begin
            cmd_o.tx_push = 1'b1;
          end
        end
        KIND_TX_DONE: cmd_o.tx_pop = ~status_i.tx_empty;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_ready_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          in_ready_q <= 1'b1;
          if (go) begin
            state_q     <= ST_RESP;
            in_ready_q  <= 1'b0;
            out_valid_q <= 1'b1;
          end
        end
        ST_RESP: begin
          if (out_ready_i) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b0;
            in_ready_q  <= 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: design/ubf_datapath.sv
// Datapath: receive and transmit rings, pointers, counts and result registers.
module ubf_datapath
  import ubf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ubf_cmd_t           cmd_i,
  input  logic [7:0]         data_i,
  output ubf_status_t        status_o,
  output logic               read_valid_o,
  output logic [7:0]         read_data_o,
  output logic               tx_strobe_o,
  output logic [7:0]         tx_byte_o,
  output logic               send_rejected_o,
  output logic [LEVEL_W-1:0] rx_level_o,
  output logic [LEVEL_W-1:0] tx_level_o
);

  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_mem [TX_DEPTH];

  logic [RX_PTR_W-1:0] rx_head_q, rx_head_d, rx_wslot;
  logic [RX_CNT_W-1:0] rx_cnt_q, rx_cnt_d;
  logic [TX_PTR_W-1:0] tx_head_q, tx_head_d, tx_wslot;
  logic [TX_CNT_W-1:0] tx_cnt_q, tx_cnt_d;
  logic [RX_PTR_W:0]   rx_sum;
  logic [TX_PTR_W:0]   tx_sum;

  logic [7:0] rx_rd_q, tx_rd_q, data_q;
  logic       read_valid_q, tx_strobe_q, tx_from_mem_q, send_rej_q;

  assign status_o.rx_empty = (rx_cnt_q == '0);
  assign status_o.rx_full  = (rx_cnt_q == RX_CNT_W'(RX_DEPTH));
  assign status_o.tx_empty = (tx_cnt_q == '0);
  assign status_o.tx_full  = (tx_cnt_q == TX_CNT_W'(TX_DEPTH));

  always_comb begin
    rx_sum = {1'b0, rx_head_q} + {1'b0, rx_cnt_q[RX_PTR_W-1:0]};
    if (status_o.rx_full) begin
      rx_wslot = (rx_head_q == '0) ? RX_PTR_W'(RX_DEPTH - 1) : rx_head_q - 1'b1;
    end else if (rx_sum >= (RX_PTR_W + 1)'(RX_DEPTH)) begin
      rx_wslot = RX_PTR_W'(rx_sum - (RX_PTR_W + 1)'(RX_DEPTH));
    end else begin
      rx_wslot = rx_sum[RX_PTR_W-1:0];
    end
    tx_sum = {1'b0, tx_head_q} + {1'b0, tx_cnt_q[TX_PTR_W-1:0]};
    if (tx_sum >= (TX_PTR_W + 1)'(TX_DEPTH)) begin
      tx_wslot = TX_PTR_W'(tx_sum - (TX_PTR_W + 1)'(TX_DEPTH));
    end else begin
      tx_wslot = tx_sum[TX_PTR_W-1:0];
    end
  end

  always_comb begin
    rx_head_d = rx_head_q;
    rx_cnt_d  = rx_cnt_q;
    tx_head_d = tx_head_q;
    tx_cnt_d  = tx_cnt_q;
    if (cmd_i.rx_push && !status_o.rx_full) begin
      rx_cnt_d = rx_cnt_q + 1'b1;
    end
    if (cmd_i.rx_pop) begin
      rx_cnt_d  = rx_cnt_q - 1'b1;
      rx_head_d = (rx_head_q == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : rx_head_q + 1'b1;
    end
    if (cmd_i.tx_push) begin
      tx_cnt_d = tx_cnt_q + 1'b1;
    end
    if (cmd_i.tx_pop) begin
      tx_cnt_d  = tx_cnt_q - 1'b1;
      tx_head_d = (tx_head_q == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : tx_head_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q     <= '0;
      rx_cnt_q      <= '0;
      tx_head_q     <= '0;
      tx_cnt_q      <= '0;
      read_valid_q  <= 1'b0;
      tx_strobe_q   <= 1'b0;
      tx_from_mem_q <= 1'b0;
      send_rej_q    <= 1'b0;
    end else begin
      rx_head_q <= rx_head_d;
      rx_cnt_q  <= rx_cnt_d;
      tx_head_q <= tx_head_d;
      tx_cnt_q  <= tx_cnt_d;
      if (cmd_i.load) begin
        read_valid_q  <= cmd_i.rx_pop;
        tx_strobe_q   <= cmd_i.tx_pop | cmd_i.tx_direct;
        tx_from_mem_q <= cmd_i.tx_pop;
        send_rej_q    <= cmd_i.send_rej;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      data_q <= data_i;
    end
    if (cmd_i.rx_push) begin
      rx_mem[rx_wslot] <= data_i;
    end
    if (cmd_i.rx_pop) begin
      rx_rd_q <= rx_mem[rx_head_q];
    end
    if (cmd_i.tx_push) begin
      tx_mem[tx_wslot] <= data_i;
    end
    if (cmd_i.tx_pop) begin
      tx_rd_q <= tx_mem[tx_head_q];
    end
  end

  assign read_valid_o    = read_valid_q;
  assign read_data_o     = read_valid_q ? rx_rd_q : 8'd0;
  assign tx_strobe_o     = tx_strobe_q;
  assign tx_byte_o       = !tx_strobe_q ? 8'd0 : (tx_from_mem_q ? tx_rd_q : data_q);
  assign send_rejected_o = send_rej_q;
  assign rx_level_o      = rx_cnt_q[LEVEL_W-1:0];
  assign tx_level_o      = tx_cnt_q[LEVEL_W-1:0];

endmodule

FILE: design/ubf_checker.sv
// Port-level checker for the buffered UART byte FIFOs, with its bind.
module ubf_checker
  import ubf_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               read_valid_o,
  input logic [7:0]         read_data_o,
  input logic               tx_strobe_o,
  input logic [7:0]         tx_byte_o,
  input logic               send_rejected_o,
  input logic [LEVEL_W-1:0] rx_level_o,
  input logic [LEVEL_W-1:0] tx_level_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o)
      && $stable(tx_byte_o) && $stable(rx_level_o) && $stable(tx_level_o))
    else $error("stalled result beat changed");

  a_one_per_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted beat gave no result next cycle");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input accepted while result pending");

  a_reject_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && send_rejected_o |-> tx_level_o == LEVEL_W'(TX_DEPTH) && !tx_strobe_o)
    else $error("send rejected without full transmit ring");

  a_read_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_valid_o |-> rx_level_o != LEVEL_W'(RX_DEPTH) && !tx_strobe_o)
    else $error("read result inconsistent with receive level");

endmodule

bind buffered_uart_byte_fifos ubf_checker u_ubf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .read_valid_o    (read_valid_o),
  .read_data_o     (read_data_o),
  .tx_strobe_o     (tx_strobe_o),
  .tx_byte_o       (tx_byte_o),
  .send_rejected_o (send_rejected_o),
  .rx_level_o      (rx_level_o),
  .tx_level_o      (tx_level_o)
);
